/* rtl/core/bloom_filter_three_hash_macros.svh */
// ----------------------------------------------------------------------------
// Bloom filter assertion macros
// Concurrent property wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BLOOM_FILTER_THREE_HASH_MACROS_SVH
`define BLOOM_FILTER_THREE_HASH_MACROS_SVH

`ifndef SYNTH

`define BFTH_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`define BFTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define BFTH_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define BFTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/core/bfth_pkg.sv */
// ----------------------------------------------------------------------------
// Bloom filter package
// Widths, hash constants and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bfth_pkg;

   localparam int unsigned ACC_W    = 64;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned CFG_W    = 17;
   localparam int unsigned N_MIN    = 2;

   localparam logic [ACC_W-1:0] DJB2_SEED = 64'd5381;
   localparam logic [CFG_W-1:0] NUM_BITS_RESET = 17'd65521;

   localparam int unsigned DJB2_SH   = 5;
   localparam int unsigned SDBM_SH_A = 6;
   localparam int unsigned SDBM_SH_B = 16;

   typedef enum logic [1:0] {
      SEL_P1 = 2'd0,
      SEL_P2 = 2'd1,
      SEL_P3 = 2'd2
   } pos_sel_type;

   typedef struct packed {
      logic        req_ready;
      logic        clr_step;
      logic        div_step;
      logic        p3a;
      logic        p3b;
      logic        mem_access;
      pos_sel_type sel;
      logic        out_load;
      logic        seed;
   } bfth_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic key_end;
      logic rsp_free;
   } bfth_status_type;

endpackage

/* rtl/core/bfth_ifs.sv */
// ----------------------------------------------------------------------------
// Bloom filter channel interfaces
// Request, response and control-register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface bfth_req_if;
   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic [bfth_pkg::BYTE_W-1:0]    key_byte;
   logic                           has_byte;
   logic                           last;

   modport source (output valid, req_type, key_byte, has_byte, last, input ready);
   modport sink   (input valid, req_type, key_byte, has_byte, last, output ready);
endinterface

interface bfth_rsp_if;
   logic valid;
   logic ready;
   logic maybe_present;
   logic was_insert;

   modport source (output valid, maybe_present, was_insert, input ready);
   modport sink   (input valid, maybe_present, was_insert, output ready);
endinterface

interface bfth_csr_if;
   logic                        valid;
   logic                        ready;
   logic [bfth_pkg::CFG_W-1:0]  num_bits;

   modport source (output valid, num_bits, input ready);
   modport sink   (input valid, num_bits, output ready);
endinterface

/* rtl/core/bfth_ram.sv */
// ----------------------------------------------------------------------------
// Bloom filter generic RAM
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfth_ram #(
   parameter int unsigned WIDTH = 1,
   parameter int unsigned DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/bfth_ctrl.sv */
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences the clear pass, key intake, remainder division and bit access.
// ----------------------------------------------------------------------------
module bfth_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  bfth_pkg::bfth_status_type st,
   output bfth_pkg::bfth_cmd_type    cmd
);

   localparam int unsigned CW = $clog2(bfth_pkg::ACC_W);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_DIV    = 8'b0000_0100,
      ST_P3A    = 8'b0000_1000,
      ST_P3B    = 8'b0001_0000,
      ST_ACCESS = 8'b0010_0000,
      ST_DRAIN  = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         div_cnt_ff, div_cnt_in;
   bfth_pkg::pos_sel_type sel_ff, sel_in;

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      sel_in     = sel_ff;
      cmd        = '0;
      cmd.sel    = sel_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            if (st.key_end) begin
               div_cnt_in = '0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == CW'(bfth_pkg::ACC_W - 1)) begin
               state_in = ST_P3A;
            end
         end
         ST_P3A: begin
            cmd.p3a  = 1'b1;
            state_in = ST_P3B;
         end
         ST_P3B: begin
            cmd.p3b  = 1'b1;
            sel_in   = bfth_pkg::SEL_P1;
            state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            cmd.mem_access = 1'b1;
            unique case (sel_ff)
               bfth_pkg::SEL_P1: sel_in = bfth_pkg::SEL_P2;
               bfth_pkg::SEL_P2: sel_in = bfth_pkg::SEL_P3;
               default: begin
                  sel_in   = bfth_pkg::SEL_P1;
                  state_in = ST_DRAIN;
               end
            endcase
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (st.rsp_free) begin
               cmd.out_load = 1'b1;
               cmd.seed     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         div_cnt_ff <= '0;
         sel_ff     <= bfth_pkg::SEL_P1;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
         sel_ff     <= sel_in;
      end
   end

endmodule

/* rtl/core/bfth_dp.sv */
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Hash accumulators, bit-serial remainder units, bit store and output register.
// ----------------------------------------------------------------------------
module bfth_dp #(
   parameter int unsigned MAX_BITS = 65536
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bfth_pkg::bfth_cmd_type     cmd,
   output bfth_pkg::bfth_status_type  st,
   bfth_req_if.sink                   req_chan,
   bfth_rsp_if.source                 rsp_chan,
   bfth_csr_if.sink                   csr_chan
);

   localparam int unsigned AW  = $clog2(MAX_BITS);
   localparam int unsigned NW  = $clog2(MAX_BITS + 1);
   localparam int unsigned EW  = (NW > bfth_pkg::CFG_W) ? NW : bfth_pkg::CFG_W;
   localparam int unsigned LAST_ADDR = MAX_BITS - 1;
   localparam int unsigned AC  = bfth_pkg::ACC_W;

   logic [bfth_pkg::CFG_W-1:0] num_bits_ff;
   logic [AC-1:0]              djb_ff, djb_in;
   logic [AC-1:0]              sdbm_ff, sdbm_in;
   logic [NW-1:0]              n_ff, n_eff;
   logic [NW-1:0]              rem1_ff, rem1_in;
   logic [NW-1:0]              rem2_ff, rem2_in;
   logic [NW:0]                p3_ff, p3_in;
   logic                       insert_ff;
   logic                       hit_ff;
   logic                       rd_pend_ff;
   logic [AW-1:0]              clr_addr_ff;
   logic                       rsp_valid_ff;
   logic                       maybe_ff;
   logic                       was_insert_ff;

   logic                       fire;
   logic [AC-1:0]              byte_ext;
   logic [EW-1:0]              nb_ext;
   logic [NW:0]                t1, t2, n_ext;
   logic [NW+1:0]              s3;
   logic [AW-1:0]              pos_addr;
   logic                       mem_en, mem_we, mem_wdata, mem_rdata;
   logic [AW-1:0]              mem_addr;

   assign req_chan.ready = cmd.req_ready;
   assign csr_chan.ready = 1'b1;
   assign fire           = req_chan.valid & cmd.req_ready;

   assign st.key_end  = fire & req_chan.last;
   assign st.clr_done = (clr_addr_ff == AW'(LAST_ADDR));
   assign st.rsp_free = ~rsp_valid_ff | rsp_chan.ready;

   assign nb_ext = EW'(num_bits_ff);

   always_comb begin
      priority if (nb_ext < EW'(bfth_pkg::N_MIN)) begin
         n_eff = NW'(bfth_pkg::N_MIN);
      end else if (nb_ext > EW'(MAX_BITS)) begin
         n_eff = NW'(MAX_BITS);
      end else begin
         n_eff = NW'(nb_ext);
      end
   end

   assign byte_ext = {{(AC - bfth_pkg::BYTE_W){req_chan.key_byte[bfth_pkg::BYTE_W-1]}},
                      req_chan.key_byte};

   assign n_ext = {1'b0, n_ff};
   assign t1    = {rem1_ff, djb_ff[AC-1]};
   assign t2    = {rem2_ff, sdbm_ff[AC-1]};
   assign s3    = {2'b00, rem1_ff} + {1'b0, rem2_ff, 1'b0};

   always_comb begin
      djb_in  = djb_ff;
      sdbm_in = sdbm_ff;
      rem1_in = rem1_ff;
      rem2_in = rem2_ff;
      p3_in   = p3_ff;
      priority if (cmd.seed) begin
         djb_in  = bfth_pkg::DJB2_SEED;
         sdbm_in = '0;
      end else if (cmd.div_step) begin
         djb_in  = {djb_ff[AC-2:0], 1'b0};
         sdbm_in = {sdbm_ff[AC-2:0], 1'b0};
         rem1_in = (t1 >= n_ext) ? NW'(t1 - n_ext) : NW'(t1);
         rem2_in = (t2 >= n_ext) ? NW'(t2 - n_ext) : NW'(t2);
      end else if (cmd.p3a) begin
         p3_in = (s3 >= {1'b0, n_ext}) ? (NW+1)'(s3 - {1'b0, n_ext}) : (NW+1)'(s3);
      end else if (cmd.p3b) begin
         p3_in = (p3_ff >= n_ext) ? (p3_ff - n_ext) : p3_ff;
      end else if (fire) begin
         if (req_chan.has_byte) begin
            djb_in  = (djb_ff << bfth_pkg::DJB2_SH) + djb_ff + byte_ext;
            sdbm_in = byte_ext + (sdbm_ff << bfth_pkg::SDBM_SH_A)
                      + (sdbm_ff << bfth_pkg::SDBM_SH_B) - sdbm_ff;
         end
         if (req_chan.last) begin
            rem1_in = '0;
            rem2_in = '0;
         end
      end
   end

   always_comb begin
      unique case (cmd.sel)
         bfth_pkg::SEL_P1: pos_addr = rem1_ff[AW-1:0];
         bfth_pkg::SEL_P2: pos_addr = rem2_ff[AW-1:0];
         bfth_pkg::SEL_P3: pos_addr = p3_ff[AW-1:0];
         default:          pos_addr = rem1_ff[AW-1:0];
      endcase
   end

   assign mem_en    = cmd.clr_step | cmd.mem_access;
   assign mem_we    = cmd.clr_step | (cmd.mem_access & insert_ff);
   assign mem_addr  = cmd.clr_step ? clr_addr_ff : pos_addr;
   assign mem_wdata = ~cmd.clr_step;

   bfth_ram #(
      .WIDTH (1),
      .DEPTH (MAX_BITS)
   ) u_bits (
      .clock (clock),
      .en    (mem_en),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         num_bits_ff  <= bfth_pkg::NUM_BITS_RESET;
         djb_ff       <= bfth_pkg::DJB2_SEED;
         sdbm_ff      <= '0;
         clr_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            num_bits_ff <= csr_chan.num_bits;
         end
         djb_ff     <= djb_in;
         sdbm_ff    <= sdbm_in;
         rd_pend_ff <= cmd.mem_access & ~insert_ff;
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem1_ff <= rem1_in;
      rem2_ff <= rem2_in;
      p3_ff   <= p3_in;
      if (st.key_end) begin
         n_ff      <= n_eff;
         insert_ff <= req_chan.req_type;
      end
      if (cmd.p3b) begin
         hit_ff <= 1'b1;
      end else if (rd_pend_ff) begin
         hit_ff <= hit_ff & mem_rdata;
      end
      if (cmd.out_load) begin
         maybe_ff      <= hit_ff & ~insert_ff;
         was_insert_ff <= insert_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.maybe_present = maybe_ff;
   assign rsp_chan.was_insert    = was_insert_ff;

endmodule

/* rtl/core/bloom_filter_three_hash.sv */
// ----------------------------------------------------------------------------
// Bloom filter engine, three positions per key
// Hashes streamed key bytes with djb2 and sdbm, then tests or sets three bits.
//
//   channel  dir  beat contents                           handshake
//   req      in   req_type, key_byte, has_byte, last      valid/ready
//   rsp      out  maybe_present, was_insert               valid/ready
//   csr      in   num_bits                                valid/ready
//
// A beat without last leaves the engine idle, ready for the next beat.
// A beat with last holds off further request beats while the bit-serial
// remainder units run, the third position forms (P3A, P3B), the three bit
// store accesses use its single port, a read drains and the output loads.
// After reset a clear pass writes one bit per cycle to all MAX_BITS addresses.
// The output register frees the engine; a stalled rsp holds the next result.
// ----------------------------------------------------------------------------
`include "bloom_filter_three_hash_macros.svh"

module bloom_filter_three_hash #(
   parameter int unsigned MAX_BITS = 65536
) (
   input  logic       clock,
   input  logic       reset,
   bfth_req_if.sink   req_chan,
   bfth_rsp_if.source rsp_chan,
   bfth_csr_if.sink   csr_chan
);

   bfth_pkg::bfth_cmd_type    cmd;
   bfth_pkg::bfth_status_type st;

   bfth_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .st    (st),
      .cmd   (cmd)
   );

   bfth_dp #(
      .MAX_BITS (MAX_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .st       (st),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   `BFTH_ASSERT_IMPL(a_no_rsp_overwrite, clock, reset, cmd.out_load, (!rsp_chan.valid || rsp_chan.ready), "result overwritten")
   `BFTH_ASSERT_IMPL(a_no_intake_in_div, clock, reset, cmd.div_step || cmd.clr_step, !req_chan.ready, "beat taken while busy")
   `BFTH_ASSERT_NEXT(a_key_end_divides, clock, reset, st.key_end, cmd.div_step, "key end did not start division")

endmodule

/* sim/tb_bloom_filter_three_hash.sv */
// ----------------------------------------------------------------------------
// Bloom filter engine testbench
// Streams keys byte by byte into the three-position filter under several bit
// counts and idle patterns, predicts djb2/sdbm positions and the bit store
// contents alongside, and checks every lookup and insert answer in order.
// ----------------------------------------------------------------------------
module tb_bloom_filter_three_hash;

   localparam int unsigned FILTER_DEPTH    = 65536;
   localparam int unsigned FILTER_AW       = $clog2(FILTER_DEPTH);
   localparam int unsigned SETTLE_CYCLES   = 80;
   localparam int unsigned HOLD_OFF_CYCLES = 600;

   typedef enum bit {OP_LOOKUP = 1'b0, OP_INSERT = 1'b1} op_type;

   typedef struct packed {
      logic maybe_present;
      logic was_insert;
   } answer_type;

   typedef struct packed {
      logic [3:0]  len;
      logic [63:0] bytes;
   } key_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bfth_req_if req_chan ();
   bfth_rsp_if rsp_chan ();
   bfth_csr_if csr_chan ();

   bloom_filter_three_hash #(.MAX_BITS(FILTER_DEPTH)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   logic [bfth_pkg::CFG_W-1:0] num_bits_model;
   logic [bfth_pkg::ACC_W-1:0] djb2_model;
   logic [bfth_pkg::ACC_W-1:0] sdbm_model;
   bit                         filter_model [0:FILTER_DEPTH-1];
   answer_type                 answers_due [$];
   key_type                    inserted_keys [$];

   int unsigned beats_counted = 0;
   int unsigned errors        = 0;
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned hold_seq      = 0;
   int unsigned hold_taken    = 0;
   int unsigned hold_left     = 0;

   always #6 clock = ~clock;

   function automatic int unsigned modulus();
      if (num_bits_model < bfth_pkg::N_MIN) return bfth_pkg::N_MIN;
      if (num_bits_model > FILTER_DEPTH) return FILTER_DEPTH;
      return 32'(num_bits_model);
   endfunction

   function automatic void hash_and_probe(input op_type op, input logic [7:0] b,
                                          input logic has, input logic last);
      logic [bfth_pkg::ACC_W-1:0] c;
      longint unsigned            n;
      longint unsigned            p1;
      longint unsigned            p2;
      longint unsigned            p3;
      answer_type                 ans;
      if (has) begin
         c = {{(bfth_pkg::ACC_W-bfth_pkg::BYTE_W){b[7]}}, b};
         djb2_model = (djb2_model << bfth_pkg::DJB2_SH) + djb2_model + c;
         sdbm_model = c + (sdbm_model << bfth_pkg::SDBM_SH_A)
                      + (sdbm_model << bfth_pkg::SDBM_SH_B) - sdbm_model;
      end
      if (!last) return;
      n  = 64'(modulus());
      p1 = djb2_model % n;
      p2 = sdbm_model % n;
      p3 = (p1 + 2 * p2) % n;
      ans.was_insert    = (op == OP_INSERT);
      ans.maybe_present = 1'b0;
      if (op == OP_INSERT) begin
         filter_model[FILTER_AW'(p1)] = 1'b1;
         filter_model[FILTER_AW'(p2)] = 1'b1;
         filter_model[FILTER_AW'(p3)] = 1'b1;
      end else begin
         ans.maybe_present = filter_model[FILTER_AW'(p1)] & filter_model[FILTER_AW'(p2)]
                             & filter_model[FILTER_AW'(p3)];
      end
      answers_due.push_back(ans);
      djb2_model = bfth_pkg::DJB2_SEED;
      sdbm_model = '0;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual %b %b",
                        $time, rsp_chan.maybe_present, rsp_chan.was_insert);
            end else begin
               answer_type exp_ans;
               exp_ans = answers_due.pop_front();
               if (rsp_chan.maybe_present !== exp_ans.maybe_present) begin
                  errors++;
                  $display("%0t: maybe_present mismatch, expected %b actual %b",
                           $time, exp_ans.maybe_present, rsp_chan.maybe_present);
               end
               if (rsp_chan.was_insert !== exp_ans.was_insert) begin
                  errors++;
                  $display("%0t: was_insert mismatch, expected %b actual %b",
                           $time, exp_ans.was_insert, rsp_chan.was_insert);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (hold_seq != hold_taken) begin
            hold_taken = hold_seq;
            hold_left  = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_beat(input op_type op, input logic [7:0] b,
                            input logic has, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= op;
      req_chan.key_byte <= b;
      req_chan.has_byte <= has;
      req_chan.last     <= last;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      hash_and_probe(op, b, has, last);
      if (has || last) beats_counted++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_num_bits(input logic [bfth_pkg::CFG_W-1:0] value);
      csr_chan.valid    <= 1'b1;
      csr_chan.num_bits <= value;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      num_bits_model = value;
   endtask

   function automatic key_type random_key();
      key_type k;
      k.len = ($urandom_range(4) == 0) ? 4'($urandom_range(8, 5)) : 4'($urandom_range(4, 0));
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(9))
            0: k.bytes[8*i +: 8] = 8'h00;
            1: k.bytes[8*i +: 8] = 8'h7F;
            2: k.bytes[8*i +: 8] = 8'h80;
            3: k.bytes[8*i +: 8] = 8'hFF;
            default: k.bytes[8*i +: 8] = 8'($urandom_range(255));
         endcase
      end
      return k;
   endfunction

   task automatic send_key(input op_type op, input key_type k);
      bit empty_tail;
      bit is_end;
      empty_tail = (k.len == 0) || ($urandom_range(6) == 0);
      for (int i = 0; i < k.len; i++) begin
         if ($urandom_range(9) == 0)
            send_beat(op_type'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 1'b0);
         is_end = !empty_tail && (i == k.len - 1);
         send_beat(is_end ? op : op_type'($urandom_range(1)), k.bytes[8*i +: 8], 1'b1,
                   is_end);
      end
      if (empty_tail) send_beat(op, 8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   task automatic run_random_keys(input int unsigned count);
      int unsigned goal;
      int unsigned pick;
      key_type     k;
      goal = beats_counted + count;
      while (beats_counted < goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            k = random_key();
            send_key(OP_INSERT, k);
            inserted_keys.push_back(k);
            if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
         end else if (pick < 75 && inserted_keys.size() != 0) begin
            send_key(OP_LOOKUP, inserted_keys[$urandom_range(inserted_keys.size() - 1)]);
         end else if (pick < 90) begin
            send_key(OP_LOOKUP, random_key());
         end else begin
            repeat ($urandom_range(3, 1))
               send_beat(op_type'($urandom_range(1)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'b0);
         end
      end
   endtask

   task automatic test_directed_keys();
      send_beat(OP_LOOKUP, 8'h00, 1'b0, 1'b1);
      send_beat(OP_INSERT, 8'hFF, 1'b0, 1'b1);
      send_beat(OP_LOOKUP, 8'h5A, 1'b0, 1'b1);
      send_beat(OP_INSERT, 8'h00, 1'b1, 1'b1);
      send_beat(OP_LOOKUP, 8'h00, 1'b1, 1'b1);
      send_beat(OP_LOOKUP, 8'h7F, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'h80, 1'b1, 1'b0);
      send_beat(OP_INSERT, 8'hFF, 1'b1, 1'b1);
      send_beat(OP_INSERT, 8'h7F, 1'b1, 1'b0);
      send_beat(OP_INSERT, 8'h80, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'hFF, 1'b1, 1'b1);
      send_beat(OP_INSERT, 8'hFF, 1'b0, 1'b0);
      send_beat(OP_LOOKUP, 8'h7F, 1'b1, 1'b0);
      send_beat(OP_INSERT, 8'h80, 1'b0, 1'b0);
      send_beat(OP_LOOKUP, 8'h80, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'hFF, 1'b1, 1'b1);
      send_beat(OP_INSERT, 8'h55, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'hAA, 1'b1, 1'b0);
      send_beat(OP_INSERT, 8'h00, 1'b0, 1'b1);
      send_beat(OP_LOOKUP, 8'h55, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'hAA, 1'b1, 1'b1);
   endtask

   task automatic test_mid_key_config();
      settle();
      send_beat(OP_INSERT, 8'h12, 1'b1, 1'b0);
      send_beat(OP_INSERT, 8'h34, 1'b1, 1'b0);
      settle();
      write_num_bits(17'd7);
      send_beat(OP_INSERT, 8'h56, 1'b1, 1'b1);
      send_beat(OP_LOOKUP, 8'h12, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'h34, 1'b1, 1'b0);
      send_beat(OP_LOOKUP, 8'h56, 1'b1, 1'b1);
   endtask

   task automatic test_no_idle();
      settle();
      write_num_bits(17'd65536);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_keys(320);
   endtask

   task automatic test_sender_gaps();
      settle();
      write_num_bits(17'h1FFFF);
      send_idle_pct = 59;
      rsp_stall_pct = 0;
      run_random_keys(300);
   endtask

   task automatic test_receiver_stalls();
      settle();
      write_num_bits(17'd1009);
      send_idle_pct = 0;
      rsp_stall_pct = 59;
      run_random_keys(300);
   endtask

   task automatic test_both_idle();
      settle();
      write_num_bits(17'd97);
      send_idle_pct = 19;
      rsp_stall_pct = 19;
      run_random_keys(300);
   endtask

   task automatic test_tiny_filter();
      settle();
      write_num_bits(17'd0);
      send_idle_pct = 19;
      rsp_stall_pct = 19;
      run_random_keys(100);
      settle();
      write_num_bits(17'd1);
      run_random_keys(100);
      settle();
      write_num_bits(17'd2);
      run_random_keys(80);
   endtask

   task automatic test_backpressure();
      settle();
      write_num_bits(bfth_pkg::NUM_BITS_RESET);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_seq <= hold_seq + 1;
      run_random_keys(150);
      rsp_stall_pct = 59;
      hold_seq <= hold_seq + 1;
      run_random_keys(150);
   endtask

   initial begin
      req_chan.valid    = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.key_byte = '0;
      req_chan.has_byte = 1'b0;
      req_chan.last     = 1'b0;
      rsp_chan.ready    = 1'b0;
      csr_chan.valid    = 1'b0;
      csr_chan.num_bits = '0;
      num_bits_model    = bfth_pkg::NUM_BITS_RESET;
      djb2_model        = bfth_pkg::DJB2_SEED;
      sdbm_model        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_keys();
      test_mid_key_config();
      test_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_tiny_filter();
      test_backpressure();
      settle();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #30000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
